// ===== src/gedge_pkg.sv =====
// Shared types and constants for the gradient edge threshold block.
`default_nettype none

package gedge_pkg;

    // Field widths of the stream items.
    localparam int PIX_W       = 8;
    localparam int OUT_ROW_W   = 12;
    localparam int OUT_COL_W   = 10;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - PIX_W - OUT_ROW_W - OUT_COL_W;

    // Configuration registers.
    localparam int COLS_W     = 11;
    localparam int ROWS_W     = 13;
    localparam int THR_W      = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_Q4 = 2'd2;

    localparam logic [COLS_W-1:0] COLS_RESET = 11'd640;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd480;
    localparam logic [THR_W-1:0]  THR_RESET  = 12'd320;

    // Gray conversion: weighted sum, then divide by 100 through a reciprocal.
    // 5243 / 2^19 overshoots 1/100 by less than 0.006 over the whole sum range,
    // which never carries a fraction of at most 0.99 across an integer.
    localparam int SUM_W      = 15;
    localparam int PROD_W     = 28;
    localparam int GRAY_SHIFT = 19;
    localparam logic [SUM_W-1:0]  GRAY_KR    = 15'd30;
    localparam logic [SUM_W-1:0]  GRAY_KG    = 15'd59;
    localparam logic [SUM_W-1:0]  GRAY_KB    = 15'd11;
    localparam logic [PROD_W-1:0] GRAY_RECIP = 28'd5243;

    // Gradient arithmetic.
    localparam int DIFF_W    = 9;
    localparam int SQ_FULL_W = 18;
    localparam int SQ_W      = 16;
    localparam int SQSUM_W   = 17;
    localparam int MAG_SHIFT = 6;
    localparam int MAG_W     = SQSUM_W + MAG_SHIFT;
    localparam int THR_SQ_W  = 2 * THR_W;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

    // Result queue.
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 9);

    // One line store entry: the gray values of the two previous rows.
    typedef struct packed {
        logic [PIX_W-1:0] two_above;
        logic [PIX_W-1:0] above;
    } line_word_t;

    localparam int LINE_W = $bits(line_word_t);

    // One result item.
    typedef struct packed {
        logic [PIX_W-1:0]     pixel_value;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 last_of_run;
    } result_t;

    // Up to two results written to the queue in one cycle, in order.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

// ===== src/gedge_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module gedge_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; a read of the address being written returns the old data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/gedge_line_store.sv =====
// Line store of the two previous gray rows with write-to-read forwarding.
`default_nettype none

module gedge_line_store #(
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire gedge_pkg::line_word_t                  wr_data,
    output gedge_pkg::line_word_t                       word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [gedge_pkg::LINE_W-1:0] ram_q;
    logic                         rd_pend_reg;
    logic [AW-1:0]                rd_addr_reg;
    logic                         fwd_hit_reg;
    gedge_pkg::line_word_t        fwd_word_reg;
    gedge_pkg::line_word_t        hold_reg;
    gedge_pkg::line_word_t        raw_word;

    gedge_ram #(
        .WIDTH (gedge_pkg::LINE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Track the last read and whether a write to the same entry raced it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            rd_addr_reg <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_en;
            if (rd_en)
            begin
                rd_addr_reg <= rd_addr;
                fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_word_reg <= wr_data;
        end
        hold_reg <= word;
    end

    // Fresh RAM data right after a read, the held copy afterwards.
    always_comb
    begin
        if (rd_pend_reg)
        begin
            raw_word = fwd_hit_reg ? fwd_word_reg : gedge_pkg::line_word_t'(ram_q);
        end
        else
        begin
            raw_word = hold_reg;
        end
    end

    // A write landing on the entry after its read replaces the copy.
    assign word = (wr_en && (wr_addr == rd_addr_reg)) ? wr_data : raw_word;

endmodule

`default_nettype wire

// ===== src/gedge_result_fifo.sv =====
// Result queue that takes up to two items per cycle and gives one.
`default_nettype none

module gedge_result_fifo (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire gedge_pkg::push_t                 push,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output gedge_pkg::result_t                    out_data,
    output logic [gedge_pkg::FIFO_CW-1:0]         count
);

    gedge_pkg::result_t                 entry_reg [gedge_pkg::FIFO_DEPTH];
    logic [gedge_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [gedge_pkg::FIFO_AW-1:0]      wr_ptr_next;
    logic [gedge_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [gedge_pkg::FIFO_AW-1:0]      rd_ptr_next;
    logic [gedge_pkg::FIFO_CW-1:0]      count_reg;
    logic [gedge_pkg::FIFO_CW-1:0]      count_next;
    logic                               pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + gedge_pkg::FIFO_AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + gedge_pkg::FIFO_AW'(pop);
        count_next  = count_reg + gedge_pkg::FIFO_CW'(push.cnt)
                      - gedge_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage; the second item goes right behind the first.
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            entry_reg[wr_ptr_reg + gedge_pkg::FIFO_AW'(1)] <= push.second;
        end
    end

    // The upstream credit check must keep the queue from overflowing.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_reg) + 32'(push.cnt) <= 32'(gedge_pkg::FIFO_DEPTH) + 32'(pop)))
        else $error("result queue overflow");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd3))
        else $error("illegal push count");

endmodule

`default_nettype wire

// ===== src/gradient_edge_threshold.sv =====
// Top level of the streaming central-difference gradient edge detector.
//
// Input: one RGB pixel per item in raster order on s_axis (red, green, blue).
// Output: m_axis carries pixel_value, out_row and out_col; tlast marks the
// last result caused by one input item. The pixel of row r-1 comes out when
// the pixel below it (row r) is taken; on the last row of a frame an item also
// gives its own border pixel, so it causes two results unless the frame has one row.
// Throughput is one item per clock while the result queue has room, set by
// the single read and single write port of the line store RAM used once per
// item. On the last row the output channel carries two results per item and
// so limits the input rate. Results pass through stages 1 to 3 and then a
// 16-entry result queue before they appear on m_axis.
// s_axis_tready drops only when the queue may not hold the results of all
// items in flight; a stalled receiver therefore backs up into s_axis after a
// few items. Reset returns the configuration registers to 640 columns, 480
// rows and threshold 320, clears the row and column counters and empties the
// queue. The line store is not cleared: the first row of a frame writes it.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
`default_nettype none

module gradient_edge_threshold #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 4096
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // tdata: red [7:0], green [15:8], blue [23:16]
    input  wire logic [gedge_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata: pixel_value [7:0], out_row [19:8], out_col [29:20], zeros above
    output logic [gedge_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                       m_axis_tlast,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [gedge_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gedge_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CW1   = $clog2(MAX_COLS + 1);
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RW1   = $clog2(MAX_ROWS + 1);

    // Configuration registers.
    logic [gedge_pkg::COLS_W-1:0]   image_cols_reg;
    logic [gedge_pkg::ROWS_W-1:0]   image_rows_reg;
    logic [gedge_pkg::THR_W-1:0]    threshold_reg;
    logic [gedge_pkg::THR_SQ_W-1:0] thr_sq_reg;
    logic [CW1-1:0]                 cols_eff;
    logic [RW1-1:0]                 rows_eff;

    // Raster position.
    logic [COL_W-1:0] col_count_reg;
    logic [COL_W-1:0] col_count_next;
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;

    // Accept stage.
    logic                           in_accept;
    logic [gedge_pkg::PIX_W-1:0]    red;
    logic [gedge_pkg::PIX_W-1:0]    green;
    logic [gedge_pkg::PIX_W-1:0]    blue;
    logic [gedge_pkg::SUM_W-1:0]    gray_sum;
    logic                           last_col;
    logic                           last_row;
    logic                           border;
    gedge_pkg::line_word_t          line_word;
    logic [gedge_pkg::PIX_W-1:0]    prev_center_reg;

    // Stage 1: gray and line store write.
    logic                           s1_valid_reg;
    logic [COL_W-1:0]               s1_col_reg;
    logic [ROW_W-1:0]               s1_row_reg;
    logic                           s1_emit_up_reg;
    logic                           s1_border_reg;
    logic                           s1_last_row_reg;
    logic [gedge_pkg::SUM_W-1:0]    s1_sum_reg;
    logic [gedge_pkg::PIX_W-1:0]    s1_center_reg;
    logic [gedge_pkg::PIX_W-1:0]    s1_up_reg;
    logic [gedge_pkg::PIX_W-1:0]    s1_left_reg;
    logic [gedge_pkg::PROD_W-1:0]   gray_prod;
    logic [gedge_pkg::PIX_W-1:0]    gray;
    logic signed [gedge_pkg::DIFF_W-1:0] diff_x;
    logic signed [gedge_pkg::DIFF_W-1:0] diff_y;
    gedge_pkg::line_word_t          wr_word;

    // Stage 2: squares.
    logic                           s2_valid_reg;
    logic [COL_W-1:0]               s2_col_reg;
    logic [ROW_W-1:0]               s2_row_reg;
    logic                           s2_emit_up_reg;
    logic                           s2_border_reg;
    logic                           s2_last_row_reg;
    logic [gedge_pkg::PIX_W-1:0]    s2_center_reg;
    logic [gedge_pkg::PIX_W-1:0]    s2_gray_reg;
    logic signed [gedge_pkg::DIFF_W-1:0] s2_dx_reg;
    logic signed [gedge_pkg::DIFF_W-1:0] s2_dy_reg;
    logic signed [gedge_pkg::SQ_FULL_W-1:0] dx_sq_full;
    logic signed [gedge_pkg::SQ_FULL_W-1:0] dy_sq_full;

    // Stage 3: threshold compare and result build.
    logic                           s3_valid_reg;
    logic [COL_W-1:0]               s3_col_reg;
    logic [ROW_W-1:0]               s3_row_reg;
    logic                           s3_emit_up_reg;
    logic                           s3_border_reg;
    logic                           s3_last_row_reg;
    logic [gedge_pkg::PIX_W-1:0]    s3_center_reg;
    logic [gedge_pkg::PIX_W-1:0]    s3_gray_reg;
    logic [gedge_pkg::SQ_W-1:0]     s3_dx2_reg;
    logic [gedge_pkg::SQ_W-1:0]     s3_dy2_reg;
    logic [gedge_pkg::SQSUM_W-1:0]  sq_sum;
    logic [gedge_pkg::MAG_W-1:0]    mag;
    logic                           flat;
    gedge_pkg::result_t             res_up;
    gedge_pkg::result_t             res_own;
    gedge_pkg::push_t               push;

    // Output side.
    gedge_pkg::result_t             fifo_out;
    logic [gedge_pkg::FIFO_CW-1:0]  fifo_count;
    logic [gedge_pkg::FILL_W-1:0]   fill_bound;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_cols_reg <= gedge_pkg::COLS_RESET;
            image_rows_reg <= gedge_pkg::ROWS_RESET;
            threshold_reg  <= gedge_pkg::THR_RESET;
            thr_sq_reg     <= gedge_pkg::THR_SQ_W'(gedge_pkg::THR_RESET)
                              * gedge_pkg::THR_SQ_W'(gedge_pkg::THR_RESET);
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    gedge_pkg::REG_IMAGE_COLS:
                    begin
                        image_cols_reg <= cfg_data[gedge_pkg::COLS_W-1:0];
                    end
                    gedge_pkg::REG_IMAGE_ROWS:
                    begin
                        image_rows_reg <= cfg_data[gedge_pkg::ROWS_W-1:0];
                    end
                    gedge_pkg::REG_THRESHOLD_Q4:
                    begin
                        threshold_reg <= cfg_data[gedge_pkg::THR_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            thr_sq_reg <= gedge_pkg::THR_SQ_W'(threshold_reg)
                          * gedge_pkg::THR_SQ_W'(threshold_reg);
        end
    end

    // Frame size in use: zero acts as one, oversize saturates.
    always_comb
    begin
        if (image_cols_reg == '0)
        begin
            cols_eff = CW1'(1);
        end
        else if (32'(image_cols_reg) > 32'(MAX_COLS))
        begin
            cols_eff = CW1'(MAX_COLS);
        end
        else
        begin
            cols_eff = CW1'(image_cols_reg);
        end

        if (image_rows_reg == '0)
        begin
            rows_eff = RW1'(1);
        end
        else if (32'(image_rows_reg) > 32'(MAX_ROWS))
        begin
            rows_eff = RW1'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RW1'(image_rows_reg);
        end
    end

    // Accept stage: position flags and weighted gray sum.
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign red       = s_axis_tdata[7:0];
    assign green     = s_axis_tdata[15:8];
    assign blue      = s_axis_tdata[23:16];

    always_comb
    begin
        gray_sum = gedge_pkg::SUM_W'(red) * gedge_pkg::GRAY_KR
                   + gedge_pkg::SUM_W'(green) * gedge_pkg::GRAY_KG
                   + gedge_pkg::SUM_W'(blue) * gedge_pkg::GRAY_KB;
        last_col = (CW1'(col_count_reg) + CW1'(1)) >= cols_eff;
        last_row = (RW1'(row_count_reg) + RW1'(1)) >= rows_eff;
        // Border test for the pixel one row up.
        border   = (row_count_reg == ROW_W'(1)) || (RW1'(row_count_reg) >= rows_eff)
                   || (col_count_reg == '0) || last_col;
    end

    // Raster counters.
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (in_accept)
        begin
            if (last_col)
            begin
                col_count_next = '0;
                row_count_next = last_row ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // Line store: each item prefetches the entry of the next column, which
    // is the right neighbor now and the center and up pixels of the next item.
    gedge_line_store #(
        .DEPTH (MAX_COLS)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (col_count_next),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (wr_word),
        .word    (line_word)
    );

    // Pipeline valid bits; no stage ever stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Capture the item; the left neighbor is the previous item's center.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prev_center_reg <= line_word.above;
        end
        s1_col_reg      <= col_count_reg;
        s1_row_reg      <= row_count_reg;
        s1_emit_up_reg  <= (row_count_reg != '0);
        s1_border_reg   <= border;
        s1_last_row_reg <= last_row;
        s1_sum_reg      <= gray_sum;
        s1_center_reg   <= line_word.above;
        s1_up_reg       <= line_word.two_above;
        s1_left_reg     <= prev_center_reg;
    end

    // Stage 1: divide by 100, shift the column down the line store, take
    // the differences.
    always_comb
    begin
        gray_prod         = gedge_pkg::PROD_W'(s1_sum_reg) * gedge_pkg::GRAY_RECIP;
        gray              = gray_prod[gedge_pkg::GRAY_SHIFT +: gedge_pkg::PIX_W];
        wr_word.two_above = s1_center_reg;
        wr_word.above     = gray;
        diff_x = $signed({1'b0, s1_left_reg}) - $signed({1'b0, line_word.above});
        diff_y = $signed({1'b0, s1_up_reg}) - $signed({1'b0, gray});
    end

    always_ff @(posedge clk)
    begin
        s2_col_reg      <= s1_col_reg;
        s2_row_reg      <= s1_row_reg;
        s2_emit_up_reg  <= s1_emit_up_reg;
        s2_border_reg   <= s1_border_reg;
        s2_last_row_reg <= s1_last_row_reg;
        s2_center_reg   <= s1_center_reg;
        s2_gray_reg     <= gray;
        s2_dx_reg       <= diff_x;
        s2_dy_reg       <= diff_y;
    end

    // Stage 2: squares of the differences.
    always_comb
    begin
        dx_sq_full = s2_dx_reg * s2_dx_reg;
        dy_sq_full = s2_dy_reg * s2_dy_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_col_reg      <= s2_col_reg;
        s3_row_reg      <= s2_row_reg;
        s3_emit_up_reg  <= s2_emit_up_reg;
        s3_border_reg   <= s2_border_reg;
        s3_last_row_reg <= s2_last_row_reg;
        s3_center_reg   <= s2_center_reg;
        s3_gray_reg     <= s2_gray_reg;
        s3_dx2_reg      <= dx_sq_full[gedge_pkg::SQ_W-1:0];
        s3_dy2_reg      <= dy_sq_full[gedge_pkg::SQ_W-1:0];
    end

    // Stage 3: compare 64 * |grad|^2 against threshold squared, build results.
    always_comb
    begin
        sq_sum = gedge_pkg::SQSUM_W'(s3_dx2_reg) + gedge_pkg::SQSUM_W'(s3_dy2_reg);
        mag    = {sq_sum, {gedge_pkg::MAG_SHIFT{1'b0}}};
        flat   = gedge_pkg::THR_SQ_W'(mag) < thr_sq_reg;

        res_up.pixel_value = s3_border_reg ? s3_center_reg
                             : (flat ? gedge_pkg::PIX_WHITE : gedge_pkg::PIX_BLACK);
        res_up.out_row     = gedge_pkg::OUT_ROW_W'(s3_row_reg - ROW_W'(1));
        res_up.out_col     = gedge_pkg::OUT_COL_W'(s3_col_reg);
        res_up.last_of_run = !s3_last_row_reg;

        res_own.pixel_value = s3_gray_reg;
        res_own.out_row     = gedge_pkg::OUT_ROW_W'(s3_row_reg);
        res_own.out_col     = gedge_pkg::OUT_COL_W'(s3_col_reg);
        res_own.last_of_run = 1'b1;

        push.second = res_own;
        push.first  = s3_emit_up_reg ? res_up : res_own;
        if (!s3_valid_reg)
        begin
            push.cnt = 2'd0;
        end
        else
        begin
            push.cnt = 2'(s3_emit_up_reg) + 2'(s3_last_row_reg);
        end
    end

    gedge_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (fifo_out),
        .count     (fifo_count)
    );

    assign m_axis_tdata = {{gedge_pkg::OUT_PAD_W{1'b0}}, fifo_out.out_col,
                           fifo_out.out_row, fifo_out.pixel_value};
    assign m_axis_tlast = fifo_out.last_of_run;

    // Take an item only if the queue can hold two results for it and for
    // every item still in the pipeline.
    always_comb
    begin
        fill_bound = gedge_pkg::FILL_W'(fifo_count)
                     + gedge_pkg::FILL_W'({s1_valid_reg, 1'b0})
                     + gedge_pkg::FILL_W'({s2_valid_reg, 1'b0})
                     + gedge_pkg::FILL_W'({s3_valid_reg, 1'b0})
                     + gedge_pkg::FILL_W'(2);
        s_axis_tready = fill_bound <= gedge_pkg::FILL_W'(gedge_pkg::FIFO_DEPTH);
    end

    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (32'(fifo_count) <= 32'(gedge_pkg::FIFO_DEPTH - 2)))
        else $error("input ready without queue room");

    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd2) |-> (s3_valid_reg && s3_emit_up_reg && s3_last_row_reg))
        else $error("two results from an item not on the last row");

    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> ($stable(col_count_reg) && $stable(row_count_reg)))
        else $error("raster position moved without an item");

    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (s1_valid_reg && (s1_col_reg == $past(col_count_reg))))
        else $error("line store write lost its column");

endmodule

`default_nettype wire

// ===== tb/gedge_scoreboard_pkg.sv =====
// Scoreboard for the gradient edge threshold block: pixel predictor and result check.
`timescale 1ns / 100ps

package gedge_scoreboard_pkg;

    import gedge_pkg::*;

    localparam int LINE_DEPTH  = 1024;
    localparam int ROW_LIMIT   = 4096;
    localparam int REPORT_MAX  = 20;

    // One expected output pixel.
    typedef struct packed {
        logic [PIX_W-1:0]     pixel_value;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 last_of_run;
    } edge_result_t;

    class edge_scoreboard;
        // Register values as last written.
        int unsigned image_cols;
        int unsigned image_rows;
        int unsigned threshold_q4;
        // Gray values of the two previous rows and the raster position.
        logic [PIX_W-1:0] gray_above [LINE_DEPTH];
        logic [PIX_W-1:0] gray_two_above [LINE_DEPTH];
        int unsigned col_pos;
        int unsigned row_pos;
        edge_result_t pending_q[$];
        int unsigned errors;
        int unsigned pixels;
        int unsigned results;
        int unsigned edges;
        int unsigned flats;
        int unsigned borders;
        int unsigned reg_writes;

        function new();
            image_cols   = 32'(COLS_RESET);
            image_rows   = 32'(ROWS_RESET);
            threshold_q4 = 32'(THR_RESET);
            col_pos      = 0;
            row_pos      = 0;
            errors       = 0;
            pixels       = 0;
            results      = 0;
            edges        = 0;
            flats        = 0;
            borders      = 0;
            reg_writes   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            reg_writes++;
            case (index)
                REG_IMAGE_COLS:   image_cols   = 32'(value[COLS_W-1:0]);
                REG_IMAGE_ROWS:   image_rows   = 32'(value[ROWS_W-1:0]);
                REG_THRESHOLD_Q4: threshold_q4 = 32'(value[THR_W-1:0]);
                default: ;
            endcase
        endfunction

        // A size of zero acts as one; anything above the limit saturates.
        function int unsigned span(int unsigned value, int unsigned limit);
            if (value == 0)
                return 1;
            if (value > limit)
                return limit;
            return value;
        endfunction

        // Work out the results caused by one accepted pixel and advance the raster.
        function void note_pixel(logic [IN_TDATA_W-1:0] tdata);
            int unsigned cols;
            int unsigned rows;
            int unsigned gray;
            int unsigned c;
            int unsigned r;
            int unsigned mag;
            int dx;
            int dy;
            logic last_col;
            logic last_row;
            logic border;
            edge_result_t res;

            cols = span(image_cols, LINE_DEPTH);
            rows = span(image_rows, ROW_LIMIT);
            gray = (30 * int'(tdata[7:0]) + 59 * int'(tdata[15:8])
                    + 11 * int'(tdata[23:16])) / 100;
            c = col_pos;
            r = row_pos;
            last_col = (c + 1 >= cols);
            last_row = (r + 1 >= rows);
            if (c >= LINE_DEPTH)
                c = LINE_DEPTH - 1;

            // The pixel one row up is finished now that the one below it is known.
            if (r > 0)
            begin
                border = (r == 1) || (r >= rows) || (c == 0) || (c + 1 >= cols);
                if (border)
                begin
                    res.pixel_value = gray_above[c];
                    borders++;
                end
                else
                begin
                    dx = int'(gray_two_above[c - 1]) - int'(gray_above[c + 1]);
                    dy = int'(gray_two_above[c]) - int'(gray);
                    mag = 64 * (dx * dx + dy * dy);
                    if (mag < threshold_q4 * threshold_q4)
                    begin
                        res.pixel_value = PIX_WHITE;
                        flats++;
                    end
                    else
                    begin
                        res.pixel_value = PIX_BLACK;
                        edges++;
                    end
                end
                res.out_row = OUT_ROW_W'(r - 1);
                res.out_col = OUT_COL_W'(c);
                res.last_of_run = !last_row;
                pending_q.push_back(res);
            end

            // On the last row the pixel itself is a border pixel.
            if (last_row)
            begin
                res.pixel_value = PIX_W'(gray);
                res.out_row = OUT_ROW_W'(r);
                res.out_col = OUT_COL_W'(c);
                res.last_of_run = 1'b1;
                pending_q.push_back(res);
                borders++;
            end

            gray_two_above[c] = gray_above[c];
            gray_above[c] = PIX_W'(gray);
            if (last_col)
            begin
                col_pos = 0;
                row_pos = last_row ? 0 : r + 1;
            end
            else
                col_pos = c + 1;
            pixels++;
        endfunction

        // Compare one accepted output item with the oldest expectation.
        function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
            edge_result_t want;
            logic [PIX_W-1:0] got_value;
            logic [OUT_ROW_W-1:0] got_row;
            logic [OUT_COL_W-1:0] got_col;
            logic [OUT_PAD_W-1:0] got_pad;

            got_value = tdata[PIX_W-1:0];
            got_row = tdata[PIX_W +: OUT_ROW_W];
            got_col = tdata[PIX_W + OUT_ROW_W +: OUT_COL_W];
            got_pad = tdata[OUT_TDATA_W-1 -: OUT_PAD_W];
            results++;
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: unexpected item, got value %0d row %0d col %0d last %0b",
                             $time, got_value, got_row, got_col, tlast);
                return;
            end
            want = pending_q.pop_front();
            if (got_value != want.pixel_value || got_row != want.out_row
                || got_col != want.out_col || tlast != want.last_of_run || got_pad != 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                begin
                    $display("%0t: mismatch, expected value %0d row %0d col %0d last %0b pad 0",
                             $time, want.pixel_value, want.out_row, want.out_col,
                             want.last_of_run);
                    $display("%0t: mismatch, got value %0d row %0d col %0d last %0b pad %0d",
                             $time, got_value, got_row, got_col, tlast, got_pad);
                end
            end
        endfunction

        function bit drained();
            return pending_q.size() == 0;
        endfunction
    endclass

endpackage

// ===== tb/gradient_edge_threshold_test.sv =====
// Top-level testbench of the gradient edge threshold block: stimulus, handshakes and verdict.
`timescale 1ns / 100ps

module gradient_edge_threshold_test;

    import gedge_pkg::*;
    import gedge_scoreboard_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_PIXELS  = 165;

    // Pixel content of a frame.
    typedef enum int { PAT_EXTREME, PAT_NOISE, PAT_SMOOTH, PAT_FLAT } pattern_t;

    logic                   clk;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned stall_cycles = 0;
    int unsigned frames;
    logic [2:0] extreme_step;
    logic [PIX_W-1:0] base_red;
    logic [PIX_W-1:0] base_green;
    logic [PIX_W-1:0] base_blue;
    edge_scoreboard pixel_check;

    gradient_edge_threshold DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock generator.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check every output item and end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            pixel_check.check_result(m_axis_tdata, m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
            $display("gradient_edge_threshold regression: fail");
            $finish;
        end
        else
            stall_cycles = stall_cycles + 1;
    end

    // A channel level with a little noise, kept inside 0..255.
    function automatic logic [PIX_W-1:0] nudge(logic [PIX_W-1:0] level);
        int v;
        v = int'(level) + int'($urandom_range(0, 12)) - 6;
        if (v < 0)
            v = 0;
        else if (v > 255)
            v = 255;
        return v[PIX_W-1:0];
    endfunction

    // Next pixel of a pattern; tdata holds red, green, blue from the low bits up.
    function automatic logic [IN_TDATA_W-1:0] make_pixel(pattern_t pattern);
        logic [2:0] mask;
        case (pattern)
            PAT_EXTREME:
            begin
                // Walk through every mix of all-zero and all-one channels.
                mask = extreme_step;
                extreme_step = extreme_step + 3'd1;
                return {{8{mask[2]}}, {8{mask[1]}}, {8{mask[0]}}};
            end
            PAT_NOISE:
                return IN_TDATA_W'($urandom());
            PAT_SMOOTH:
            begin
                // Mostly gentle slopes, with an occasional step that makes an edge.
                if ($urandom_range(0, 15) == 0)
                begin
                    base_red = PIX_W'($urandom_range(0, 255));
                    base_green = PIX_W'($urandom_range(0, 255));
                    base_blue = PIX_W'($urandom_range(0, 255));
                end
                return {nudge(base_blue), nudge(base_green), nudge(base_red)};
            end
            default:
                return {base_blue, base_green, base_red};
        endcase
    endfunction

    function automatic int unsigned pick_threshold();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 4095;
            2: return $urandom_range(0, 4095);
            default: return $urandom_range(100, 1500);
        endcase
    endfunction

    // Present one pixel after a random number of idle cycles and hold it until taken.
    task automatic send_pixel(input logic [IN_TDATA_W-1:0] pixel);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pixel;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pixel_check.note_pixel(pixel);
        @(negedge clk);
    endtask

    // Stop sending, wait for every expected item, then let the pipeline settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (!pixel_check.drained())
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one register while the block is idle.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] index, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        pixel_check.write_reg(index, value[CFG_DATA_W-1:0]);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input int unsigned cols, input int unsigned rows,
                             input int unsigned thr);
        drain();
        set_reg(REG_IMAGE_COLS, cols);
        set_reg(REG_IMAGE_ROWS, rows);
        set_reg(REG_THRESHOLD_Q4, thr);
    endtask

    // Send one frame from the top-left pixel until the raster wraps. After resize_after
    // pixels the block is drained and shrunk to new_cols / new_rows (negative keeps a size).
    task automatic run_frame(input pattern_t pattern, input int resize_after = -1,
                             input int new_cols = -1, input int new_rows = -1);
        int sent;
        sent = 0;
        base_red = PIX_W'($urandom_range(0, 255));
        base_green = PIX_W'($urandom_range(0, 255));
        base_blue = PIX_W'($urandom_range(0, 255));
        do
        begin
            if (sent == resize_after)
            begin
                drain();
                if (new_cols >= 0)
                    set_reg(REG_IMAGE_COLS, new_cols);
                if (new_rows >= 0)
                    set_reg(REG_IMAGE_ROWS, new_rows);
            end
            send_pixel(make_pixel(pattern));
            sent++;
        end
        while (pixel_check.col_pos != 0 || pixel_check.row_pos != 0);
        frames++;
    endtask

    // Stimulus sequence.
    initial
    begin
        int unsigned cols;
        int unsigned rows;
        int unsigned stop;
        int unsigned phase_start;
        int unsigned pick;
        bit shrunk;
        pattern_t pattern;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_IMAGE_COLS;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        frames = 0;
        extreme_step = '0;
        cols = 0;
        rows = 0;
        shrunk = 1'b1;
        pixel_check = new();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero sizes act as a single pixel frame: each pixel is its own border result.
        configure(0, 0, 4095);
        run_frame(PAT_EXTREME);
        run_frame(PAT_EXTREME);
        // Smallest frame with an interior pixel, at both threshold extremes.
        configure(3, 3, 0);
        run_frame(PAT_EXTREME);
        configure(3, 3, 4095);
        run_frame(PAT_EXTREME);
        // Oversized registers, then shrunk below the current column mid-frame.
        configure(2047, 8191, 32'(THR_RESET));
        run_frame(PAT_NOISE, 3, 2, 2);

        // Random frames under four handshake mixes.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 71;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 71;
                end
                default:
                begin
                    send_idle_pct = 18;
                    recv_stall_pct = 18;
                end
            endcase
            phase_start = pixel_check.pixels;
            while (pixel_check.pixels - phase_start < PHASE_PIXELS)
            begin
                pick = $urandom_range(0, 11);
                pattern = pattern_t'($urandom_range(0, 3));
                if (pick == 0)
                begin
                    // Saturating sizes, cut back early in the first row.
                    cols = $urandom_range(0, 1) ? 2047 : $urandom_range(1024, 2047);
                    rows = $urandom_range(0, 1) ? 8191 : $urandom_range(4096, 8191);
                    configure(cols, rows, pick_threshold());
                    run_frame(pattern, $urandom_range(1, 30), $urandom_range(0, 40),
                              $urandom_range(0, 6));
                    shrunk = 1'b1;
                end
                else
                begin
                    if (shrunk || $urandom_range(0, 2) != 0)
                    begin
                        case ($urandom_range(0, 9))
                            0:
                            begin
                                cols = $urandom_range(0, 2);
                                rows = $urandom_range(0, 8);
                            end
                            1:
                            begin
                                cols = $urandom_range(17, 64);
                                rows = $urandom_range(3, 4);
                            end
                            2:
                            begin
                                cols = $urandom_range(3, 16);
                                rows = $urandom_range(0, 2);
                            end
                            default:
                            begin
                                cols = $urandom_range(3, 16);
                                rows = $urandom_range(3, 8);
                            end
                        endcase
                        configure(cols, rows, pick_threshold());
                        shrunk = 1'b0;
                    end
                    // Now and then shrink a size below the current position mid-frame.
                    if (pick <= 2 && cols >= 2 && rows >= 2)
                    begin
                        stop = $urandom_range(1, cols * rows - 1);
                        if ($urandom_range(0, 1) && stop / cols > 0)
                            run_frame(pattern, stop, -1, $urandom_range(0, stop / cols));
                        else
                            run_frame(pattern, stop, $urandom_range(0, stop % cols), -1);
                        shrunk = 1'b1;
                    end
                    else
                        run_frame(pattern);
                end
            end
        end

        drain();
        $display("Covered %0d pixels in %0d frames with %0d register writes, four handshake mixes.",
                 pixel_check.pixels, frames, pixel_check.reg_writes);
        $display("Checked %0d output items: %0d border, %0d flat, %0d edge; %0d errors.",
                 pixel_check.results, pixel_check.borders, pixel_check.flats,
                 pixel_check.edges, pixel_check.errors);
        if (pixel_check.errors == 0)
            $display("gradient_edge_threshold regression: pass");
        else
            $display("gradient_edge_threshold regression: fail");
        $finish;
    end

endmodule
